### hdl/tsp_pkg.sv
// Shared types and constants for the triangular self-product block.
package tsp_pkg;

   localparam int ELEM_W = 32;
   localparam int ACC_W  = 72;

   localparam logic [0:0] REG_MODE  = 1'b0;
   localparam logic [0:0] REG_ORDER = 1'b1;

   // job handed from the loader to the compute engine
   typedef struct packed {
      logic       lower;
      logic [3:0] n;
   } job_type;

   function automatic logic [ELEM_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      logic signed [ACC_W-25:0] s;
      t = acc + ACC_W'(25'sh0800000);
      s = t[ACC_W-1:24];
      if (s > 48'sh7FFFFFFF) begin
         round_sat = 32'h7FFFFFFF;
      end else if (s < -48'sh80000000) begin
         round_sat = 32'h80000000;
      end else begin
         round_sat = s[ELEM_W-1:0];
      end
   endfunction

endpackage

### hdl/tsp_ram.sv
// Generic single-port-write, dual-read RAM with registered reads.
module tsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

### hdl/tsp_load.sv
// Front end: counts incoming elements and issues a job per full matrix.
module tsp_load
   import tsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        lower,
   input  logic [3:0]  n,
   input  logic        clear,
   input  logic        done,
   output logic        wr_en,
   output logic [5:0]  wr_addr,
   output logic        job_valid,
   output job_type     job
);
   logic [2:0] r_ff, r_in, c_ff, c_in;
   logic       last;

   // single-slot queue to the engine: loader waits while a job is pending
   logic    pend_ff;
   assign in_ready  = !pend_ff;
   assign wr_en     = in_valid && in_ready;
   assign wr_addr   = {c_ff, r_ff};
   assign last      = (r_ff == 3'(n - 4'd1)) && (c_ff == 3'(n - 4'd1));
   assign job_valid = wr_en && last;
   assign job       = '{lower: lower, n: n};

   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      if (wr_en) begin
         if (r_ff == 3'(n - 4'd1)) begin
            r_in = '0;
            c_in = last ? 3'd0 : c_ff + 3'd1;
         end else begin
            r_in = r_ff + 3'd1;
         end
      end
      if (clear) begin
         r_in = '0;
         c_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;
         c_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         r_ff <= r_in;
         c_ff <= c_in;
         // cleared by the engine's done pulse
         pend_ff <= job_valid ? 1'b1 : (done ? 1'b0 : pend_ff);
      end
   end
endmodule

### hdl/tsp_engine.sv
// Back end: per result element, MAC over k then round (or pass through), emit.
module tsp_engine
   import tsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        done,
   output logic [5:0]  rd_addr_a,
   output logic [5:0]  rd_addr_b,
   input  logic [31:0] rd_data_a,
   input  logic [31:0] rd_data_b,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_value,
   output logic [2:0]  out_row,
   output logic [2:0]  out_col,
   output logic        out_last
);
   localparam logic [2:0] S_IDLE = 3'd0, S_SETUP = 3'd1, S_MAC = 3'd2,
                          S_DRAIN = 3'd3, S_EMIT = 3'd4;

   logic [2:0] st_ff, st_in;
   job_type    job_ff;
   logic [2:0] r_ff, c_ff, k_ff;
   logic       pass_ff;
   logic       rd_v_ff, rd_v2_ff, rd_pass_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [2:0] nm1;
   logic       diag_side;
   logic       k_last;

   assign nm1 = 3'(job_ff.n - 4'd1);
   assign diag_side = job_ff.lower ? (r_ff >= c_ff) : (r_ff <= c_ff);
   assign k_last = (k_ff == nm1);

   always_comb begin
      if (pass_ff) begin
         rd_addr_a = {c_ff, r_ff};
         rd_addr_b = {c_ff, r_ff};
      end else if (job_ff.lower) begin
         rd_addr_a = {r_ff, k_ff};
         rd_addr_b = {c_ff, k_ff};
      end else begin
         rd_addr_a = {k_ff, r_ff};
         rd_addr_b = {k_ff, c_ff};
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:  if (job_valid) st_in = S_SETUP;
         S_SETUP: st_in = S_MAC;
         S_MAC:   if (pass_ff || k_last) st_in = S_DRAIN;
         S_DRAIN: if (!rd_v_ff && !rd_v2_ff) st_in = S_EMIT;
         S_EMIT:  if (out_ready) st_in = out_last ? S_IDLE : S_SETUP;
         default: st_in = S_IDLE;
      endcase
   end

   assign done = (st_ff == S_EMIT) && out_ready && out_last;
   assign out_valid = (st_ff == S_EMIT);
   assign out_row = r_ff;
   assign out_col = c_ff;
   assign out_last = (r_ff == nm1) && (c_ff == nm1);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rd_v_ff <= 1'b0;
         rd_v2_ff <= 1'b0;
         r_ff <= '0;
         c_ff <= '0;
      end else begin
         st_ff <= st_in;
         rd_v_ff <= (st_ff == S_MAC);
         rd_v2_ff <= rd_v_ff && !rd_pass_ff;
         if (st_ff == S_IDLE && job_valid) begin
            r_ff <= '0;
            c_ff <= '0;
         end else if (st_ff == S_EMIT && out_ready) begin
            if (r_ff == nm1) begin
               r_ff <= '0;
               c_ff <= c_ff + 3'd1;
            end else begin
               r_ff <= r_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && job_valid) job_ff <= job;
      if (st_ff == S_SETUP) begin
         pass_ff <= !diag_side;
         k_ff <= job_ff.lower ? r_ff : c_ff;
         acc_ff <= '0;
      end
      if (st_ff == S_MAC) k_ff <= k_ff + 3'd1;
      rd_pass_ff <= pass_ff;
      if (rd_v_ff) begin
         if (rd_pass_ff) begin
            out_value <= rd_data_a;
         end else begin
            prod_ff <= $signed(rd_data_a) * $signed(rd_data_b);
         end
      end
      if (rd_v2_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
      if (st_ff == S_DRAIN && !rd_v_ff && !rd_v2_ff && !pass_ff) begin
         out_value <= round_sat(acc_ff);
      end
   end
endmodule

### hdl/triangular_self_product.sv
// Top level of the triangular self-product block.
// Usage:
//  req_ channel carries one matrix element per item (Q8.24), column-major.
//  After the n*n-th element the matrix is handed to the compute engine and
//  the whole result matrix streams out on rsp_, column-major, with tlast on
//  the final element. tuser carries {col_index, row_index} (row lowest).
//  csr_ writes: index 0 triangle_mode, index 1 order (restarts a load).
// Flow: loading takes one element per cycle while no job is pending. Each
//  result element takes setup, read and drain, plus a step per product
//  term on the single multiplier/accumulator; n(n+1)(n+2)/6 products total.
//  The next matrix can load only after the previous result has been sent.
// Reset: mode upper, order 8, load count zero. A stalled rsp_tready holds
//  the current result and pauses the engine.
module triangular_self_product
   import tsp_pkg::*;
#(
   parameter int MAX_ORDER = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // value
   output logic [5:0]  rsp_tuser,    // row_index[2:0], col_index[5:3]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);
   logic       mode_ff;
   logic [3:0] order_ff;
   logic [3:0] n_eff;
   logic       clear;
   logic       wr_en, job_valid, done;
   logic [5:0] wr_addr, ra, rb;
   logic [31:0] da, db;
   job_type    job;
   logic [2:0] row, col;

   assign csr_ready = 1'b1;
   assign clear = csr_valid && (csr_index == REG_ORDER);
   assign n_eff = (order_ff == 4'd0) ? 4'd1 :
                  (order_ff > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         order_ff <= 4'(MAX_ORDER);
      end else begin
         if (csr_valid && csr_index == REG_MODE) mode_ff <= csr_data[0];
         if (clear) order_ff <= csr_data;
      end
   end

   tsp_load u_load (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .lower(mode_ff), .n(n_eff), .clear, .done,
      .wr_en, .wr_addr, .job_valid, .job
   );

   tsp_ram #(.WIDTH(32), .DEPTH(64)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data(req_tdata),
      .rd_addr_a(ra), .rd_data_a(da), .rd_addr_b(rb), .rd_data_b(db)
   );

   tsp_engine u_engine (
      .clock, .reset, .job_valid, .job, .done,
      .rd_addr_a(ra), .rd_addr_b(rb), .rd_data_a(da), .rd_data_b(db),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_value(rsp_tdata),
      .out_row(row), .out_col(col), .out_last(rsp_tlast)
   );

   assign rsp_tuser = {col, row};
endmodule

### sim/triangular_self_product_tb.sv
// Self-checking testbench for the triangular self-product block.
module triangular_self_product_tb
   import tsp_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 150;

   typedef enum logic {ROW_CFG, ROW_ELEM} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [0:0]  idx;
      logic [31:0] data;
      bit          chk;
      logic [31:0] expv;
   } stim_row_type;

   typedef struct {
      logic [31:0] value;
      logic [2:0]  row;
      logic [2:0]  col;
      logic        last;
   } matrix_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [3:0]  csr_data = '0;

   // shadow of the block state
   logic [31:0] shadow_mat [64];
   int          loaded_elems;
   logic        lower_mode;
   logic [3:0]  order_reg;

   matrix_elem_type product_q [$];
   int  errors = 0;
   int  items_sent = 0;
   int  idle_cycles = 0;
   bit  gaps_on = 1'b1;
   bit  hold_req = 1'b0;

   triangular_self_product dut (.*);

   always #1 clock = ~clock;

   function automatic int active_order();
      if (order_reg == 4'd0) return 1;
      if (order_reg > 4'd8) return 8;
      return int'(order_reg);
   endfunction

   function automatic logic [31:0] product_entry(int r, int c, int n);
      logic signed [71:0] acc;
      logic signed [71:0] s;
      acc = '0;
      if (!lower_mode) begin
         if (r > c) return shadow_mat[c*8+r];
         for (int k = c; k < n; k++)
            acc = acc + $signed(shadow_mat[k*8+r]) * $signed(shadow_mat[k*8+c]);
      end else begin
         if (r < c) return shadow_mat[c*8+r];
         for (int k = r; k < n; k++)
            acc = acc + $signed(shadow_mat[r*8+k]) * $signed(shadow_mat[c*8+k]);
      end
      s = (acc + 72'sd8388608) >>> 24;
      if (s > 72'sd2147483647) return 32'h7FFFFFFF;
      if (s < -72'sd2147483648) return 32'h80000000;
      return s[31:0];
   endfunction

   function automatic void load_element(logic [31:0] d);
      int n;
      int k;
      matrix_elem_type e;
      n = active_order();
      k = loaded_elems;
      if (k >= n*n) k = 0;
      shadow_mat[(k/n)*8 + k%n] = d;
      k++;
      if (k < n*n) begin
         loaded_elems = k;
         return;
      end
      loaded_elems = 0;
      for (int c = 0; c < n; c++)
         for (int r = 0; r < n; r++) begin
            e.value = product_entry(r, c, n);
            e.row   = 3'(r);
            e.col   = 3'(c);
            e.last  = (r == n-1) && (c == n-1);
            product_q.push_back(e);
         end
   endfunction

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (product_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [3:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MODE) begin
         lower_mode = v[0];
      end else begin
         order_reg    = v;
         loaded_elems = 0;
      end
   endtask

   task automatic send_elem(input logic [31:0] d);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      load_element(d);
      items_sent++;
   endtask

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         1: return 32'($signed($urandom_range(0, 32'h03FFFFFF)) - 32'sh02000000);
         default: return $urandom;
      endcase
   endfunction

   // directed rows; expected values typed only for order-1 squares
   stim_row_type dir_tab [] = '{
      '{ROW_CFG,  REG_ORDER, 32'd1,        1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h01000000, 1'b1, 32'h01000000},
      '{ROW_ELEM, 1'b0,      32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF},
      '{ROW_ELEM, 1'b0,      32'h80000000, 1'b1, 32'h7FFFFFFF},
      '{ROW_ELEM, 1'b0,      32'h00000000, 1'b1, 32'h00000000},
      '{ROW_ELEM, 1'b0,      32'hFFFFFFFF, 1'b1, 32'h00000000},
      '{ROW_ELEM, 1'b0,      32'h00001000, 1'b1, 32'h00000001},
      '{ROW_CFG,  REG_MODE,  32'd1,        1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h00800000, 1'b1, 32'h00400000},
      '{ROW_CFG,  REG_MODE,  32'd0,        1'b0, 32'h0},
      '{ROW_CFG,  REG_ORDER, 32'd2,        1'b0, 32'h0},
      // negative saturation above the diagonal
      '{ROW_ELEM, 1'b0,      32'h00000000, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h12345678, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h7FFFFFFF, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h80000000, 1'b0, 32'h0},
      '{ROW_CFG,  REG_MODE,  32'd1,        1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h01800000, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'hFE000000, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h7FFFFFFF, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h00C00000, 1'b0, 32'h0},
      // partial load abandoned by an order write
      '{ROW_ELEM, 1'b0,      32'h11111111, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h22222222, 1'b0, 32'h0},
      '{ROW_CFG,  REG_ORDER, 32'd2,        1'b0, 32'h0},
      // mode changed mid-load: the later mode rules
      '{ROW_ELEM, 1'b0,      32'h00400000, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'hFF000000, 1'b0, 32'h0},
      '{ROW_CFG,  REG_MODE,  32'd0,        1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h03000000, 1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'hFD000000, 1'b0, 32'h0},
      // order zero acts as one
      '{ROW_CFG,  REG_ORDER, 32'd0,        1'b0, 32'h0},
      '{ROW_ELEM, 1'b0,      32'h02000000, 1'b1, 32'h04000000}
   };

   // receiver: random stalls plus one long hold-off
   initial begin
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      matrix_elem_type e;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (product_q.size() == 0) begin
            $error("unexpected item: value %h", rsp_tdata);
            errors++;
         end else begin
            e = product_q.pop_front();
            if (rsp_tdata !== e.value) begin
               $error("value: expected %h, got %h", e.value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[2:0] !== e.row) begin
               $error("row_index: expected %0d, got %0d", e.row, rsp_tuser[2:0]);
               errors++;
            end
            if (rsp_tuser[5:3] !== e.col) begin
               $error("col_index: expected %0d, got %0d", e.col, rsp_tuser[5:3]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_of_run: expected %0d, got %0d", e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      int phase;
      int n;
      lower_mode   = 1'b0;
      order_reg    = 4'd8;
      loaded_elems = 0;
      foreach (shadow_mat[i]) shadow_mat[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CFG) begin
            write_reg(dir_tab[i].idx, dir_tab[i].data[3:0]);
         end else begin
            send_elem(dir_tab[i].data);
            if (dir_tab[i].chk) product_q[$].value = dir_tab[i].expv;
         end
      end

      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent > RANDOM_ITEMS - 40) gaps_on = 1'b0;
         write_reg(REG_MODE, 4'($urandom_range(0, 1)));
         if (phase == 0) write_reg(REG_ORDER, 4'd15);
         else if (phase == 1) write_reg(REG_ORDER, 4'd8);
         else if ($urandom_range(0, 5) == 0) write_reg(REG_ORDER, 4'd0);
         else write_reg(REG_ORDER, 4'($urandom_range(1, 5)));
         n = active_order();
         if (phase == 3) hold_req = 1'b1;
         // now and then a broken load, abandoned by the next order write
         if (phase > 3 && n > 1 && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, n*n-1)) send_elem(rand_elem());
         end else begin
            // back-to-back matrices so a held receiver stalls the input
            repeat ((phase == 3) ? 3 : 1)
               repeat (n*n) send_elem(rand_elem());
         end
         phase++;
      end

      wait_idle();
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
